// File: design/sfvd_pkg.sv
package sfvd_pkg;

  // Frame layout
  localparam int SYNC_LEN      = 3;
  localparam int PAYLOAD_BYTES = 14;
  localparam int NUM_VALUES    = 6;
  localparam int PHASE_W       = 5;
  localparam int SUM_W         = 19;
  localparam int LIM_W         = 17;

  localparam logic [7:0] SYNC_RESET = 8'd66;
  localparam logic [15:0] CHK_MOD   = 16'd32767;

  localparam logic [PHASE_W-1:0] LAST_PHASE    = PHASE_W'(SYNC_LEN + PAYLOAD_BYTES - 1);
  localparam logic [PHASE_W-1:0] CHK_LOW_PHASE = PHASE_W'(SYNC_LEN + PAYLOAD_BYTES - 2);

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic signed [15:0] vel_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [LIM_W-1:0] lim_t;

  // sign(s) * (|s| mod 32767); 2^15 = 1 mod 32767, so fold the top bits onto
  // the low 15 and finish with a single conditional subtract.
  function automatic lim_t reduce_sum(input sum_t s);
    logic [SUM_W-2:0] mag;
    logic [15:0]      fold;
    logic [15:0]      rem;
    mag  = s[SUM_W-1] ? (SUM_W-1)'(-s) : (SUM_W-1)'(s);
    fold = 16'(mag[SUM_W-2:15]) + 16'(mag[14:0]);
    rem  = (fold >= CHK_MOD) ? (fold - CHK_MOD) : fold;
    return s[SUM_W-1] ? -lim_t'({1'b0, rem}) : lim_t'({1'b0, rem});
  endfunction

endpackage

// File: design/sync_framed_velocity_deframer.sv
// Byte-stream deframer: hunts for SYNC_LEN bytes equal to sync_value, then
// takes a 14-byte little-endian payload (three linear and three angular
// velocities, then a checksum, all signed 16-bit) and emits one result per
// frame with the six velocities and frame_ok set when the checksum equals
// sign(sum) * (|sum| mod 32767) of the velocity sum. Any non-sync byte during
// the hunt restarts it. One byte is taken every clock; the frame result is
// registered when the last payload byte is taken. The only stall on rx is
// the last byte of a frame arriving while the previous result still waits
// at the output register. sync_value may be written at any time (ready is
// always high) but should change only while the block is idle.
module sync_framed_velocity_deframer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          sync_value,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output sfvd_pkg::vel_t      lin_vel_a,
  output sfvd_pkg::vel_t      lin_vel_b,
  output sfvd_pkg::vel_t      lin_vel_c,
  output sfvd_pkg::vel_t      ang_vel_a,
  output sfvd_pkg::vel_t      ang_vel_b,
  output sfvd_pkg::vel_t      ang_vel_c,
  output logic                frame_ok
);
  import sfvd_pkg::*;

  logic [7:0]   sync_reg;
  phase_t       phase;
  logic [7:0]   low_byte_hold;
  sum_t         running_sum;
  lim_t         lim_hold;
  vel_t         value_store [NUM_VALUES];
  vel_t         vel_out [NUM_VALUES];

  logic         accept;
  logic         hunting;
  phase_t       k;
  logic [2:0]   idx;
  logic [15:0]  word;

  assign cfg_ready = 1'b1;

  // Only the frame's closing byte needs the output register free
  assign in_stall = out_valid && out_stall && (phase == LAST_PHASE);
  assign accept   = in_valid && !in_stall;

  assign hunting = (phase < phase_t'(SYNC_LEN));
  assign k       = phase - phase_t'(SYNC_LEN);
  assign idx     = k[3:1];
  assign word    = {rx_byte, low_byte_hold};

  // Control and framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg      <= SYNC_RESET;
      phase         <= '0;
      low_byte_hold <= '0;
      running_sum   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        sync_reg <= sync_value;
      end
      // result leaves unless a new frame closes in the same cycle
      if (out_valid && !out_stall && !(accept && (phase == LAST_PHASE))) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (hunting) begin
          if (rx_byte == sync_reg) begin
            phase <= phase + 1'b1;
            if (phase == phase_t'(SYNC_LEN - 1)) begin
              running_sum   <= '0;
              low_byte_hold <= '0;
            end
          end else begin
            phase <= '0;
          end
        end else if (phase > LAST_PHASE) begin
          phase <= '0;
        end else if (!k[0]) begin
          low_byte_hold <= rx_byte;
          phase         <= phase + 1'b1;
        end else if (idx < 3'(NUM_VALUES)) begin
          running_sum <= running_sum + sum_t'(signed'(word));
          phase       <= phase + 1'b1;
        end else begin
          // checksum high byte: close the frame
          out_valid   <= 1'b1;
          phase       <= '0;
          running_sum <= '0;
        end
      end
    end
  end

  // Payload storage and result register
  always_ff @(posedge clk) begin
    if (accept && !hunting && (phase <= LAST_PHASE)) begin
      if (!k[0]) begin
        if (phase == CHK_LOW_PHASE) begin
          lim_hold <= reduce_sum(running_sum);
        end
      end else if (idx < 3'(NUM_VALUES)) begin
        value_store[idx] <= vel_t'(word);
      end else begin
        vel_out  <= value_store;
        frame_ok <= (lim_hold == lim_t'(signed'(word)));
      end
    end
  end

  assign lin_vel_a = vel_out[0];
  assign lin_vel_b = vel_out[1];
  assign lin_vel_c = vel_out[2];
  assign ang_vel_a = vel_out[3];
  assign ang_vel_b = vel_out[4];
  assign ang_vel_c = vel_out[5];

  // Checks
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= LAST_PHASE)
    else $error("phase beyond frame end");

  a_close_emits: assert property (@(posedge clk) disable iff (rst)
    accept && (phase == LAST_PHASE) |=> out_valid && (phase == '0))
    else $error("frame close did not produce a result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && (phase == LAST_PHASE))
    else $error("input stalled without a pending result");

  a_new_result_only_at_close: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(accept) && ($past(phase) == LAST_PHASE))
    else $error("result appeared outside frame close");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sfvd_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS = 400;

  typedef struct {
    vel_t vel [NUM_VALUES];
    logic ok;
  } frame_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] sync_value;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  vel_t       lin_vel_a, lin_vel_b, lin_vel_c;
  vel_t       ang_vel_a, ang_vel_b, ang_vel_c;
  logic       frame_ok;

  // Deframer model state
  int         hunt_phase = 0;
  logic [7:0] held_low = '0;
  vel_t       vel_store [NUM_VALUES];
  sum_t       vel_sum = '0;
  logic [7:0] sync_match = SYNC_RESET;

  frame_t expected_frames [$];
  string  field_names [NUM_VALUES] = '{"lin_vel_a", "lin_vel_b", "lin_vel_c",
                                       "ang_vel_a", "ang_vel_b", "ang_vel_c"};

  int fail_count = 0;
  int cycle_count = 0;
  int accepted_bytes = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  sync_framed_velocity_deframer u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .sync_value (sync_value),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .lin_vel_a  (lin_vel_a),
    .lin_vel_b  (lin_vel_b),
    .lin_vel_c  (lin_vel_c),
    .ang_vel_a  (ang_vel_a),
    .ang_vel_b  (ang_vel_b),
    .ang_vel_c  (ang_vel_c),
    .frame_ok   (frame_ok)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // sign(s) * (|s| mod 32767)
  function automatic int reduce_velocity_sum(input int s);
    int mag;
    int rem;
    mag = (s < 0) ? -s : s;
    rem = mag % 32767;
    return (s < 0) ? -rem : rem;
  endfunction

  function automatic vel_t frame_checksum(input vel_t vels [NUM_VALUES]);
    int s;
    s = 0;
    foreach (vels[i]) s += int'(vels[i]);
    return vel_t'(reduce_velocity_sum(s));
  endfunction

  // Advance the deframer model by one accepted byte
  task automatic predict_byte(input logic [7:0] b);
    int          k;
    logic [15:0] word;
    frame_t      f;
    if (hunt_phase < SYNC_LEN) begin
      if (b == sync_match) begin
        hunt_phase++;
        if (hunt_phase == SYNC_LEN) begin
          vel_sum  = '0;
          held_low = '0;
        end
      end else begin
        hunt_phase = 0;
      end
    end else begin
      k = hunt_phase - SYNC_LEN;
      if (k >= PAYLOAD_BYTES) begin
        hunt_phase = 0;
      end else if (k % 2 == 0) begin
        held_low = b;
        hunt_phase++;
      end else begin
        word = {b, held_low};
        if (k / 2 < NUM_VALUES) begin
          vel_store[k / 2] = vel_t'(word);
          vel_sum = vel_sum + vel_t'(word);
          hunt_phase++;
        end else begin
          // checksum word closes the frame
          f.vel = vel_store;
          f.ok  = (reduce_velocity_sum(int'(vel_sum)) == int'(vel_t'(word)));
          expected_frames.push_back(f);
          hunt_phase = 0;
          vel_sum    = '0;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    frame_t want;
    vel_t   got [NUM_VALUES];
    if (!rst && out_valid && !out_stall) begin
      got = '{lin_vel_a, lin_vel_b, lin_vel_c, ang_vel_a, ang_vel_b, ang_vel_c};
      if (expected_frames.size() == 0) begin
        $error("frame result with no frame expected");
        fail_count++;
      end else begin
        want = expected_frames.pop_front();
        foreach (got[i]) check_field(field_names[i], int'(want.vel[i]), int'(got[i]));
        check_field("frame_ok", int'(want.ok), int'(frame_ok));
      end
    end
  end

  // Send one byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
    accepted_bytes++;
  endtask

  task automatic send_frame(input vel_t vels [NUM_VALUES], input vel_t chk);
    repeat (SYNC_LEN) send_byte(sync_match);
    foreach (vels[i]) begin
      send_byte(vels[i][7:0]);
      send_byte(vels[i][15:8]);
    end
    send_byte(chk[7:0]);
    send_byte(chk[15:8]);
  endtask

  // Let every expected frame arrive, then let the pipeline settle
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync_value(input logic [7:0] v);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    sync_value <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sync_match = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic vel_t random_velocity();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return -16'sd1;
      4:       return vel_t'({sync_match, sync_match});
      5:       return vel_t'($signed(17'($urandom_range(0, 200)) - 17'sd100));
      default: return vel_t'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] non_sync_byte();
    return sync_match ^ 8'($urandom_range(1, 255));
  endfunction

  // Extremes, checksum cases and a broken hunt
  task automatic test_directed_frames();
    vel_t vels [NUM_VALUES];
    // two sync bytes then a break: hunt restarts
    send_byte(sync_match);
    send_byte(sync_match);
    send_byte(non_sync_byte());
    vels = '{default: '0};
    send_frame(vels, frame_checksum(vels));
    vels = '{default: 16'sh7FFF};
    send_frame(vels, frame_checksum(vels));
    vels = '{default: 16'sh8000};
    send_frame(vels, frame_checksum(vels));
    // sync bytes inside the payload are plain data
    vels = '{default: vel_t'({sync_match, sync_match})};
    send_frame(vels, frame_checksum(vels));
    // rejected frame, bad checksum
    vels = '{16'sd1000, -16'sd2000, 16'sd3, 16'sh7FFF, -16'sd1, 16'sd12345};
    send_frame(vels, frame_checksum(vels) + 16'sd1);
    // most negative checksum can never match
    vels = '{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
    send_frame(vels, 16'sh8000);
    wait_until_drained();
  endtask

  // Sync register at its extremes
  task automatic test_sync_register();
    vel_t vels [NUM_VALUES];
    write_sync_value(8'h00);
    vels = '{16'sd0, 16'sd1, 16'sd256, -16'sd256, 16'sh7F00, 16'sh00FF};
    send_frame(vels, frame_checksum(vels));
    wait_until_drained();
    write_sync_value(8'hFF);
    vels = '{-16'sd1, 16'sh00FF, 16'shFF00, -16'sd1, 16'sd0, 16'sh7FFF};
    send_frame(vels, frame_checksum(vels));
    wait_until_drained();
    write_sync_value(SYNC_RESET);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken hunts
  task automatic run_random_bytes(input int count);
    int   target;
    int   pick;
    vel_t vels [NUM_VALUES];
    vel_t chk;
    target = accepted_bytes + count;
    while (accepted_bytes < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // occasional extra sync byte, taken as payload
        if ($urandom_range(0, 9) == 0) send_byte(sync_match);
        foreach (vels[i]) vels[i] = random_velocity();
        chk = frame_checksum(vels);
        case ($urandom_range(0, 19))
          0, 1:    chk = vel_t'($urandom);
          2:       chk = chk + 16'sd1;
          3:       chk = chk - 16'sd1;
          4:       chk = 16'sh8000;
          5:       chk = -chk;
          default: ;
        endcase
        send_frame(vels, chk);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, SYNC_LEN - 1)) send_byte(sync_match);
        send_byte(non_sync_byte());
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end
    end
    wait_until_drained();
  endtask

  task automatic test_random_traffic();
    logic [7:0] phase_sync [4];
    int         phase_send_idle [4] = '{0, 81, 0, 26};
    int         phase_stall [4] = '{0, 0, 81, 26};
    phase_sync = '{8'hFF, 8'h00, 8'($urandom), SYNC_RESET};
    for (int p = 0; p < 4; p++) begin
      write_sync_value(phase_sync[p]);
      send_idle_pct = phase_send_idle[p];
      stall_pct     = phase_stall[p];
      run_random_bytes(PHASE_ITEMS);
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    sync_value = SYNC_RESET;
    in_valid   = 1'b0;
    rx_byte    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_sync_register();
    test_random_traffic();
    wait_until_drained();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
